// ----- rtl/core/odo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, register codes and constants of the two-pod odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

  typedef enum logic [1:0] {
    CMD_PIN  = 2'd0,
    CMD_POLL = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_POD1_REV = 3'd0,
    REG_POD2_REV = 3'd1,
    REG_MPC      = 3'd2,
    REG_APC      = 3'd3,
    REG_RADIUS   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_S1,
    B_S2,
    B_HEAD,
    B_CLO,
    B_CHI,
    B_BXY,
    B_ROT,
    B_MLO,
    B_MHI,
    B_DONE
  } bstate_t;

  typedef struct packed {
    logic        pod1_reverse;
    logic        pod2_reverse;
    logic [31:0] metres_per_count;
    logic [23:0] angle_per_count;
    logic [15:0] radius_ratio;
  } cfg_t;

  // One request as classified by the front end.
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [47:0] nx;
    logic signed [47:0] ny;
    logic signed [31:0] nh;
  } entry_t;

  localparam int          QUEUE_DEPTH = 4;
  localparam longint      DELTA_MAX   = 64'sd2147483647;
  localparam longint      BODY_MAX    = 64'sd140737488355327;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  function automatic logic [31:0] atan_units(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/odo_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module odo_queue import odo_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  entry_t                     push_data,
  input  logic                       pop,
  output entry_t                     head,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign full  = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/odo_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_front
// Accepts requests, tracks both encoder counters and captures poll deltas.
// ----------------------------------------------------------------------------
module odo_front import odo_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic               pod1_a,
  input  logic               pod1_b,
  input  logic               pod2_a,
  input  logic               pod2_b,
  input  logic signed [47:0] new_x,
  input  logic signed [47:0] new_y,
  input  logic signed [31:0] new_heading,
  input  logic               q_full,
  output logic               push,
  output entry_t             push_data
);

  localparam int WB = ((COUNT_BITS > 33) ? COUNT_BITS : 33) + 1;

  logic [COUNT_BITS-1:0] count_one;
  logic [COUNT_BITS-1:0] count_two;
  logic [COUNT_BITS-1:0] seen_one;
  logic [COUNT_BITS-1:0] seen_two;
  logic                  prior_a_one;
  logic                  prior_a_two;
  cmd_t                  kind;
  logic signed [31:0]    d1;
  logic signed [31:0]    d2;

  function automatic logic signed [31:0] pod_delta(input logic [COUNT_BITS-1:0] now,
                                                   input logic [COUNT_BITS-1:0] seen,
                                                   input logic rev);
    logic signed [COUNT_BITS-1:0] raw;
    logic signed [WB-1:0]         w;
    logic signed [31:0]           c;
    raw = $signed(now - seen);
    w   = WB'(raw);
    if (w > WB'(DELTA_MAX)) begin
      c = 32'sh7fff_ffff;
    end else if (w < -WB'(DELTA_MAX)) begin
      c = -32'sh7fff_ffff;
    end else begin
      c = 32'(w);
    end
    return rev ? -c : c;
  endfunction

  assign kind     = cmd_t'(cmd);
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign d1       = pod_delta(count_one, seen_one, cfg.pod1_reverse);
  assign d2       = pod_delta(count_two, seen_two, cfg.pod2_reverse);

  always_comb begin
    push_data.cmd = kind;
    push_data.d1  = d1;
    push_data.d2  = d2;
    push_data.nx  = new_x;
    push_data.ny  = new_y;
    push_data.nh  = new_heading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_one   <= '0;
      count_two   <= '0;
      seen_one    <= '0;
      seen_two    <= '0;
      prior_a_one <= 1'b0;
      prior_a_two <= 1'b0;
    end else if (push) begin
      case (kind)
        CMD_PIN: begin
          // count on each edge of A: down when A matches B
          if (pod1_a != prior_a_one) begin
            count_one   <= (pod1_a == pod1_b) ? count_one - 1'b1 : count_one + 1'b1;
            prior_a_one <= pod1_a;
          end
          if (pod2_a != prior_a_two) begin
            count_two   <= (pod2_a == pod2_b) ? count_two - 1'b1 : count_two + 1'b1;
            prior_a_two <= pod2_a;
          end
        end
        CMD_POLL: begin
          seen_one <= count_one;
          seen_two <= count_two;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/odo_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_back
// Executes queued requests: pose load, dead-reckoning update, result register.
// ----------------------------------------------------------------------------
module odo_back import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int POS_BITS     = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  entry_t             hd,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pose_x,
  output logic signed [47:0] pose_y,
  output logic signed [31:0] pose_heading,
  output logic               moved
);

  localparam int          SW        = $clog2(CORDIC_STEPS);
  localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);

  bstate_t state, state_next;

  logic signed [POS_BITS-1:0] x_store, x_next;
  logic signed [POS_BITS-1:0] y_store, y_next;
  logic signed [31:0]         heading_store, heading_next;

  logic signed [31:0] d1, d2;
  logic signed [47:0] s1, s2;
  logic signed [48:0] diff;
  logic        [31:0] plo;
  logic signed [50:0] corr;
  logic signed [51:0] bx, by;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic               flip;
  logic [SW-1:0]      step;
  logic [1:0]         k;
  logic signed [64:0] plow;
  logic signed [57:0] dxa, dya;

  logic slot_free, head_move, start, load_simple, load_poll;

  logic signed [31:0] ms_d;
  logic signed [64:0] mprod;
  logic signed [47:0] msat;
  logic signed [32:0] hdelta;
  logic signed [57:0] hprod;
  logic signed [32:0] dhi;
  logic signed [49:0] cprod;
  logic signed [32:0] zi;
  logic signed [33:0] sx, sy;
  logic signed [51:0] mv;
  logic signed [33:0] mw;
  logic signed [21:0] mvh;
  logic signed [55:0] mhprod;
  logic signed [57:0] pterm;

  assign slot_free = !out_valid || out_ready;
  assign head_move = (hd.d1 != '0) || (hd.d2 != '0);

  // shared multiplier for the two distances
  assign ms_d  = (state == B_S1) ? d1 : d2;
  assign mprod = ms_d * $signed({1'b0, cfg.metres_per_count});
  assign msat  = (mprod > 65'(BODY_MAX)) ? 48'(BODY_MAX) :
                 (mprod < -65'(BODY_MAX) - 65'sd1) ? 48'(-BODY_MAX - 64'sd1) :
                 48'(mprod);

  assign hdelta = 33'(d2) - 33'(d1);
  assign hprod  = hdelta * $signed({1'b0, cfg.angle_per_count});
  assign dhi    = diff[48:16];
  assign cprod  = dhi * $signed({1'b0, cfg.radius_ratio});
  assign zi     = 33'(heading_store);
  assign sx     = cy >>> step;
  assign sy     = cx >>> step;

  // product order: bx*c, by*s, bx*s, by*c
  assign mv     = (k == 2'd0 || k == 2'd2) ? bx : by;
  assign mw     = (k == 2'd0 || k == 2'd3) ? (flip ? -cx : cx) : (flip ? -cy : cy);
  assign mvh    = mv[51:30];
  assign mhprod = mvh * mw;
  assign pterm  = 58'(mhprod) + 58'(plow >>> 30);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && hd.cmd == CMD_POLL && head_move) begin
          state_next = B_S1;
        end
      end
      B_S1:   state_next = B_S2;
      B_S2:   state_next = B_HEAD;
      B_HEAD: state_next = B_CLO;
      B_CLO:  state_next = B_CHI;
      B_CHI:  state_next = B_BXY;
      B_BXY:  state_next = B_ROT;
      B_ROT: begin
        if (step == STEP_LAST) begin
          state_next = B_MLO;
        end
      end
      B_MLO:  state_next = B_MHI;
      B_MHI:  state_next = (k == 2'd3) ? B_DONE : B_MLO;
      B_DONE: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    start       = (state == B_IDLE) && !q_empty && hd.cmd == CMD_POLL && head_move;
    load_simple = (state == B_IDLE) && !q_empty && !start && slot_free;
    load_poll   = (state == B_DONE) && slot_free;
    pop         = start || load_simple;
  end

  always_comb begin
    x_next       = x_store;
    y_next       = y_store;
    heading_next = heading_store;
    if (load_simple && hd.cmd == CMD_SET) begin
      x_next       = POS_BITS'(hd.nx);
      y_next       = POS_BITS'(hd.ny);
      heading_next = hd.nh;
    end else if (load_poll) begin
      x_next = x_store + POS_BITS'(dxa);
      y_next = y_store + POS_BITS'(dya);
    end else if (state == B_HEAD) begin
      heading_next = heading_store + hprod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      out_valid     <= 1'b0;
      x_store       <= '0;
      y_store       <= '0;
      heading_store <= '0;
    end else begin
      state         <= state_next;
      x_store       <= x_next;
      y_store       <= y_next;
      heading_store <= heading_next;
      if (load_simple || load_poll) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_simple || load_poll) begin
      pose_x       <= 48'(x_next);
      pose_y       <= 48'(y_next);
      pose_heading <= heading_next;
      moved        <= load_poll;
    end
    if (start) begin
      d1 <= hd.d1;
      d2 <= hd.d2;
    end
    case (state)
      B_S1:  s1 <= msat;
      B_S2:  s2 <= msat;
      B_HEAD: diff <= 49'(s2) - 49'(s1);
      B_CLO: plo <= {16'b0, diff[15:0]} * {16'b0, cfg.radius_ratio};
      B_CHI: corr <= 51'(cprod) + 51'($signed({1'b0, plo[31:16]}));
      B_BXY: begin
        bx   <= 52'(s1) + 52'(corr);
        by   <= 52'(s2) - 52'(corr);
        cx   <= 34'($signed({1'b0, GAIN_Q30}));
        cy   <= '0;
        step <= '0;
        k    <= '0;
        // turn by pi when beyond a quarter turn, negate at the end
        if (zi > 33'sd1073741824 || zi < -33'sd1073741824) begin
          cz   <= 33'($signed(heading_store + 32'h8000_0000));
          flip <= 1'b1;
        end else begin
          cz   <= zi;
          flip <= 1'b0;
        end
      end
      B_ROT: begin
        if (cz >= 0) begin
          cx <= cx - sx;
          cy <= cy + sy;
          cz <= cz - $signed({1'b0, atan_units(5'(step))});
        end else begin
          cx <= cx + sx;
          cy <= cy - sy;
          cz <= cz + $signed({1'b0, atan_units(5'(step))});
        end
        step <= step + 1'b1;
      end
      B_MLO: plow <= $signed({1'b0, mv[29:0]}) * mw;
      B_MHI: begin
        case (k)
          2'd0:    dxa <= pterm;
          2'd1:    dxa <= dxa - pterm;
          2'd2:    dya <= pterm;
          default: dya <= dya + pterm;
        endcase
        k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/two_pod_quadrature_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_pod_quadrature_odometry
// Dead-reckoning pose tracker fed by two quadrature encoder pods.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: pin samples update the encoder
// counters, polls integrate the motion since the last poll, set loads the pose.
// Every request gives one result on out_valid/out_ready carrying the pose
// after that request and a moved flag.
// The front end takes one request per cycle while the four-entry queue has
// room. Pin samples, set, unused codes and polls without counter change leave
// the back end straight from the queue head into the result register, and such
// requests sustain one per cycle while the receiver takes each result.
// A poll with motion holds the back end through two distance multiplies,
// heading and radial correction, one CORDIC rotation per cycle and four split
// Q30 products, each taken in a low and a high step.
// When the receiver stalls, the result register holds; the back end stops at
// its next result and the queue then fills, dropping in_ready.
// Synchronous reset clears counters, pose and queue and restores register
// defaults; configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module two_pod_quadrature_odometry import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int COUNT_BITS   = 32,
  parameter int POS_BITS     = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic               pod1_a,
  input  logic               pod1_b,
  input  logic               pod2_a,
  input  logic               pod2_b,
  input  logic signed [47:0] new_x,
  input  logic signed [47:0] new_y,
  input  logic signed [31:0] new_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pose_x,
  output logic signed [47:0] pose_y,
  output logic signed [31:0] pose_heading,
  output logic               moved
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg;
  entry_t        push_data;
  entry_t        head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic [CW-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pod1_reverse     <= 1'b0;
      cfg.pod2_reverse     <= 1'b0;
      cfg.metres_per_count <= 32'd164710;
      cfg.angle_per_count  <= 24'd131072;
      cfg.radius_ratio     <= 16'd32768;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POD1_REV: cfg.pod1_reverse     <= cfg_data[0];
        REG_POD2_REV: cfg.pod2_reverse     <= cfg_data[0];
        REG_MPC:      cfg.metres_per_count <= cfg_data;
        REG_APC:      cfg.angle_per_count  <= cfg_data[23:0];
        REG_RADIUS:   cfg.radius_ratio     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  odo_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pod1_a     (pod1_a),
    .pod1_b     (pod1_b),
    .pod2_a     (pod2_a),
    .pod2_b     (pod2_b),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_heading(new_heading),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  odo_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  odo_back #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .POS_BITS    (POS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hd          (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pose_x      (pose_x),
    .pose_y      (pose_y),
    .pose_heading(pose_heading),
    .moved       (moved)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("request queue count beyond depth");

  a_ready_tracks_room: assert property (@(posedge clk) disable iff (rst)
    in_ready == (q_count != CW'(QUEUE_DEPTH)))
    else $error("in_ready disagrees with queue room");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("back end took a request from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule
